>>> sv/epr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epr_pkg: shared types, constants and functions
// Number formats, the Q1.30 sine table and the rounding and saturation
// helpers used by the lanes and the rotate stage of the point rotator.
// ---------------------------------------------------------------------------
package epr_pkg;

  // design constants
  localparam int COORD_BITS     = 16;
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int WORK_FRAC      = 16;
  localparam int OUT_FRAC       = 8;

  // port field widths
  localparam int FIELD_W    = 16;
  localparam int OUT_W      = 25;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 80;

  // pipeline depth: fold, six sine steps, six rotate steps
  localparam int LANE_STAGES = 7;
  localparam int ROT_STAGES  = 6;
  localparam int NSTAGE      = LANE_STAGES + ROT_STAGES;

  // rotate datapath widths
  localparam int TW      = TRIG_FRAC_BITS + 2;
  localparam int PW      = COORD_BITS + TW;
  localparam int TO_WORK = TRIG_FRAC_BITS - WORK_FRAC;
  localparam int TO_OUT  = TRIG_FRAC_BITS + WORK_FRAC - OUT_FRAC;
  localparam int SHL     = (TO_WORK < 0) ? -TO_WORK : 0;
  localparam int UW      = PW + 1 + SHL;
  localparam int SBU_W   = TW + UW;
  localparam int PSUM_W  = UW + 1;
  localparam int MPROD_W = TW + PSUM_W;
  localparam int ACC_W   = MPROD_W + 2;

  // quarter sine widths
  localparam int G_W     = 25;
  localparam int R_W     = 20;
  localparam int IDX_W   = 5;
  localparam int TAB_W   = 31;
  localparam int Q_SH    = 30;
  localparam int D_W     = 27;
  localparam int D2_W    = 24;
  localparam int CD_W    = 28;
  localparam int D3_W    = 21;
  localparam int SD2_W   = 24;
  localparam int POS_W   = 32;
  localparam int CD3_W   = 22;
  localparam int Q6_W    = 20;
  localparam int DIV6_W  = 25;
  localparam int DIV6_SH = 27;
  localparam int MAG_W   = TRIG_FRAC_BITS + 1;
  localparam int DP_W    = R_W + D_W;
  localparam int D2P_W   = 2 * D_W;
  localparam int CDP_W   = TAB_W + D_W;
  localparam int D3P_W   = D2_W + D_W;
  localparam int SD2P_W  = TAB_W + D2_W;
  localparam int CD3P_W  = TAB_W + D3_W;
  localparam int Q6P_W   = CD3_W + DIV6_W;

  localparam logic [D_W-1:0]    PI32_Q30  = 27'd105414357;
  localparam logic [DIV6_W-1:0] DIV6_M    = 25'd22369622;
  localparam logic [TAB_W-1:0]  QONE      = 31'd1073741824;
  localparam logic [IDX_W-1:0]  SIN_LAST  = 5'd16;
  localparam logic [G_W-1:0]    G_ONE     = 25'd16777216;
  localparam logic [POS_W-1:0]  TRIG_HALF = POS_W'(1) << (29 - TRIG_FRAC_BITS);

  // types
  typedef logic [ANGLE_BITS-1:0]      angle_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TW-1:0]       trig_t;
  typedef logic signed [PW-1:0]       prod_t;
  typedef logic signed [UW-1:0]       u_t;
  typedef logic signed [SBU_W-1:0]    sbu_t;
  typedef logic signed [PSUM_W-1:0]   psum_t;
  typedef logic signed [MPROD_W-1:0]  mprod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [OUT_W-1:0]    out_t;

  typedef struct packed {
    coord_t k;
    coord_t j;
    coord_t i;
  } point_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } sincos_t;

  typedef struct packed {
    logic           neg;
    logic [G_W-1:0] g;
  } fold_t;

  typedef struct packed {
    out_t rot_z;
    out_t rot_y;
    out_t rot_x;
  } res_t;

  localparam acc_t OUT_HI = acc_t'((1 <<< (OUT_W - 1)) - 1);
  localparam acc_t OUT_LO = acc_t'(-(1 <<< (OUT_W - 1)));

  // sin(k*pi/32) in Q1.30, k = 0..16
  function automatic logic [TAB_W-1:0] sine_tab(input logic [IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    unique case (idx)
      5'd0:  v = 31'd0;
      5'd1:  v = 31'd105245103;
      5'd2:  v = 31'd209476638;
      5'd3:  v = 31'd311690799;
      5'd4:  v = 31'd410903207;
      5'd5:  v = 31'd506158392;
      5'd6:  v = 31'd596538995;
      5'd7:  v = 31'd681174602;
      5'd8:  v = 31'd759250125;
      5'd9:  v = 31'd830013654;
      5'd10: v = 31'd892783698;
      5'd11: v = 31'd946955747;
      5'd12: v = 31'd992008094;
      5'd13: v = 31'd1027506862;
      5'd14: v = 31'd1053110176;
      5'd15: v = 31'd1068571464;
      5'd16: v = 31'd1073741824;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // shift by s with round half up, left shift when s is not positive
  function automatic acc_t rnd_sh(input acc_t x, input int s);
    acc_t half;
    half = acc_t'(1) <<< ((s > 0) ? (s - 1) : 0);
    if (s <= 0) begin
      return x <<< (-s);
    end
    return (x + half) >>> s;
  endfunction

  // clamp to the result range
  function automatic out_t sat_out(input acc_t x);
    acc_t y;
    y = x;
    if (y > OUT_HI) begin
      y = OUT_HI;
    end
    if (y < OUT_LO) begin
      y = OUT_LO;
    end
    return out_t'(y);
  endfunction

endpackage

>>> sv/epr_qsin.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epr_qsin: pipelined quarter-wave sine
// Table lookup plus third order Taylor correction over six stages, then
// rounding to the trig format and the quadrant sign.
// ---------------------------------------------------------------------------
module epr_qsin (
  input  logic                  clk,
  input  logic                  en,
  input  epr_pkg::fold_t        fin,
  output epr_pkg::trig_t        trig
);

  logic [epr_pkg::IDX_W-1:0]  idx;
  logic [epr_pkg::R_W-1:0]    r;
  logic [epr_pkg::DP_W-1:0]   dprod;
  logic [epr_pkg::D2P_W-1:0]  d2prod;
  logic [epr_pkg::CDP_W-1:0]  cdprod;
  logic [epr_pkg::D3P_W-1:0]  d3prod;
  logic [epr_pkg::SD2P_W-1:0] sd2prod;
  logic [epr_pkg::CD3P_W-1:0] cd3prod;
  logic [epr_pkg::Q6P_W-1:0]  q6prod;

  // stage 1
  logic [epr_pkg::D_W-1:0]   d1_r;
  logic [epr_pkg::TAB_W-1:0] s0_1_r, c0_1_r;
  logic                      full1_r, neg1_r;
  // stage 2
  logic [epr_pkg::D_W-1:0]   d_2_r;
  logic [epr_pkg::D2_W-1:0]  d2_2_r;
  logic [epr_pkg::CD_W-1:0]  cd_2_r;
  logic [epr_pkg::TAB_W-1:0] s0_2_r, c0_2_r;
  logic                      full2_r, neg2_r;
  // stage 3
  logic [epr_pkg::D3_W-1:0]  d3_3_r;
  logic [epr_pkg::SD2_W-1:0] sd2_3_r;
  logic [epr_pkg::POS_W-1:0] pos_3_r;
  logic [epr_pkg::TAB_W-1:0] c0_3_r;
  logic                      full3_r, neg3_r;
  // stage 4
  logic [epr_pkg::CD3_W-1:0] cd3_4_r;
  logic [epr_pkg::SD2_W-1:0] sd2_4_r;
  logic [epr_pkg::POS_W-1:0] pos_4_r;
  logic                      full4_r, neg4_r;
  // stage 5
  logic [epr_pkg::Q6_W-1:0]  q6_5_r;
  logic [epr_pkg::SD2_W-1:0] sd2_5_r;
  logic [epr_pkg::POS_W-1:0] pos_5_r;
  logic                      full5_r, neg5_r;
  // stage 6
  logic [epr_pkg::POS_W-1:0] negsum, diff, rnd;
  logic [epr_pkg::TAB_W-1:0] qv;
  logic [epr_pkg::MAG_W-1:0] mag;
  epr_pkg::trig_t            magx, trig_nxt, trig_r;

  // products between stages
  always_comb begin
    idx     = fin.g[epr_pkg::R_W +: epr_pkg::IDX_W];
    r       = fin.g[epr_pkg::R_W-1:0];
    dprod   = {{epr_pkg::D_W{1'b0}}, r} * {{epr_pkg::R_W{1'b0}}, epr_pkg::PI32_Q30};
    d2prod  = {{epr_pkg::D_W{1'b0}}, d1_r} * {{epr_pkg::D_W{1'b0}}, d1_r};
    cdprod  = {{epr_pkg::D_W{1'b0}}, c0_1_r} * {{epr_pkg::TAB_W{1'b0}}, d1_r};
    d3prod  = {{epr_pkg::D_W{1'b0}}, d2_2_r} * {{epr_pkg::D2_W{1'b0}}, d_2_r};
    sd2prod = {{epr_pkg::D2_W{1'b0}}, s0_2_r} * {{epr_pkg::TAB_W{1'b0}}, d2_2_r};
    cd3prod = {{epr_pkg::D3_W{1'b0}}, c0_3_r} * {{epr_pkg::TAB_W{1'b0}}, d3_3_r};
    q6prod  = {{epr_pkg::DIV6_W{1'b0}}, cd3_4_r} * {{epr_pkg::CD3_W{1'b0}}, epr_pkg::DIV6_M};
  end

  // step offset, table samples
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r    <= dprod[epr_pkg::R_W +: epr_pkg::D_W];
      s0_1_r  <= epr_pkg::sine_tab(idx);
      c0_1_r  <= epr_pkg::sine_tab(epr_pkg::SIN_LAST - idx);
      full1_r <= (idx >= epr_pkg::SIN_LAST);
      neg1_r  <= fin.neg;
    end
  end

  // square term and first order term
  always_ff @(posedge clk) begin
    if (en) begin
      d_2_r   <= d1_r;
      d2_2_r  <= d2prod[epr_pkg::Q_SH +: epr_pkg::D2_W];
      cd_2_r  <= cdprod[epr_pkg::Q_SH +: epr_pkg::CD_W];
      s0_2_r  <= s0_1_r;
      c0_2_r  <= c0_1_r;
      full2_r <= full1_r;
      neg2_r  <= neg1_r;
    end
  end

  // cube term, second order term, positive sum
  always_ff @(posedge clk) begin
    if (en) begin
      d3_3_r  <= d3prod[epr_pkg::Q_SH +: epr_pkg::D3_W];
      sd2_3_r <= sd2prod[(epr_pkg::Q_SH + 1) +: epr_pkg::SD2_W];
      pos_3_r <= {{(epr_pkg::POS_W - epr_pkg::TAB_W){1'b0}}, s0_2_r}
               + {{(epr_pkg::POS_W - epr_pkg::CD_W){1'b0}}, cd_2_r};
      c0_3_r  <= c0_2_r;
      full3_r <= full2_r;
      neg3_r  <= neg2_r;
    end
  end

  // third order term before the divide by six
  always_ff @(posedge clk) begin
    if (en) begin
      cd3_4_r <= cd3prod[epr_pkg::Q_SH +: epr_pkg::CD3_W];
      sd2_4_r <= sd2_3_r;
      pos_4_r <= pos_3_r;
      full4_r <= full3_r;
      neg4_r  <= neg3_r;
    end
  end

  // divide by six through the reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      q6_5_r  <= q6prod[epr_pkg::DIV6_SH +: epr_pkg::Q6_W];
      sd2_5_r <= sd2_4_r;
      pos_5_r <= pos_4_r;
      full5_r <= full4_r;
      neg5_r  <= neg4_r;
    end
  end

  // combine, clamp, round and sign
  always_comb begin
    negsum = {{(epr_pkg::POS_W - epr_pkg::SD2_W){1'b0}}, sd2_5_r}
           + {{(epr_pkg::POS_W - epr_pkg::Q6_W){1'b0}}, q6_5_r};
    diff   = pos_5_r - negsum;
    priority if (full5_r) begin
      qv = epr_pkg::QONE;
    end else if (negsum >= pos_5_r) begin
      qv = '0;
    end else if (diff > {1'b0, epr_pkg::QONE}) begin
      qv = epr_pkg::QONE;
    end else begin
      qv = diff[epr_pkg::TAB_W-1:0];
    end
    rnd      = {1'b0, qv} + epr_pkg::TRIG_HALF;
    mag      = rnd[(epr_pkg::TAB_W - 1) -: epr_pkg::MAG_W];
    magx     = epr_pkg::trig_t'({1'b0, mag});
    trig_nxt = neg5_r ? -magx : magx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

>>> sv/epr_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epr_lane: sine and cosine of one angle
// Folds the phase into a quarter turn for both functions and runs two
// quarter-sine pipelines side by side.
// ---------------------------------------------------------------------------
module epr_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [epr_pkg::FIELD_W-1:0]   angle,
  output epr_pkg::sincos_t              sc
);

  // fold a phase into a fraction of a quarter turn and a sign
  function automatic epr_pkg::fold_t phase_fold(input epr_pkg::angle_t p);
    epr_pkg::fold_t             res;
    logic [epr_pkg::ANGLE_BITS-3:0] q;
    logic [23:0]                f;
    q       = p[epr_pkg::ANGLE_BITS-3:0];
    f       = {q, {(26 - epr_pkg::ANGLE_BITS){1'b0}}};
    res.neg = p[epr_pkg::ANGLE_BITS-1];
    res.g   = p[epr_pkg::ANGLE_BITS-2] ? (epr_pkg::G_ONE - {1'b0, f}) : {1'b0, f};
    return res;
  endfunction

  epr_pkg::angle_t ph, phc;
  epr_pkg::fold_t  fold_sin_r, fold_cos_r;

  // cosine is sine a quarter turn ahead
  always_comb begin
    ph  = epr_pkg::angle_t'(angle);
    phc = ph + (epr_pkg::angle_t'(1) << (epr_pkg::ANGLE_BITS - 2));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold_sin_r <= phase_fold(ph);
      fold_cos_r <= phase_fold(phc);
    end
  end

  epr_qsin u_sin (
    .clk  (clk),
    .en   (en),
    .fin  (fold_sin_r),
    .trig (sc.s)
  );

  epr_qsin u_cos (
    .clk  (clk),
    .en   (en),
    .fin  (fold_cos_r),
    .trig (sc.c)
  );

endmodule

>>> sv/epr_rotate.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// epr_rotate: merge of the three angle lanes
// Applies the three rotations to the point in six registered steps,
// products and sums in alternate steps, with rounding and saturation to Q16.8.
// ---------------------------------------------------------------------------
module epr_rotate (
  input  logic              clk,
  input  logic              en,
  input  epr_pkg::point_t   pt,
  input  epr_pkg::sincos_t  ang_a,
  input  epr_pkg::sincos_t  ang_b,
  input  epr_pkg::sincos_t  ang_c,
  output epr_pkg::res_t     res
);

  epr_pkg::prod_t  jsa_r, kca_r, jca_r, ksa_r, icb_r, isb_r;
  epr_pkg::trig_t  sb1_r, cb1_r, cc1_r, sc1_r;
  epr_pkg::u_t     u_r, v2_r, icbw2_r;
  epr_pkg::prod_t  isb2_r;
  epr_pkg::trig_t  sb2_r, cb2_r, cc2_r, sc2_r;
  epr_pkg::sbu_t   sbu_r, cbu_r;
  epr_pkg::u_t     icbw3_r, v3_r;
  epr_pkg::prod_t  isb3_r;
  epr_pkg::trig_t  cc3_r, sc3_r;
  epr_pkg::psum_t  p_r;
  epr_pkg::u_t     v4_r;
  epr_pkg::out_t   z4_r, z5_r;
  epr_pkg::trig_t  cc4_r, sc4_r;
  epr_pkg::mprod_t ccp_r, scv_r, ccv_r, scp_r;
  epr_pkg::res_t   res_r;

  // coordinate by trig products
  always_ff @(posedge clk) begin
    if (en) begin
      jsa_r <= epr_pkg::prod_t'(pt.j) * epr_pkg::prod_t'(ang_a.s);
      kca_r <= epr_pkg::prod_t'(pt.k) * epr_pkg::prod_t'(ang_a.c);
      jca_r <= epr_pkg::prod_t'(pt.j) * epr_pkg::prod_t'(ang_a.c);
      ksa_r <= epr_pkg::prod_t'(pt.k) * epr_pkg::prod_t'(ang_a.s);
      icb_r <= epr_pkg::prod_t'(pt.i) * epr_pkg::prod_t'(ang_b.c);
      isb_r <= epr_pkg::prod_t'(pt.i) * epr_pkg::prod_t'(ang_b.s);
      sb1_r <= ang_b.s;
      cb1_r <= ang_b.c;
      cc1_r <= ang_c.c;
      sc1_r <= ang_c.s;
    end
  end

  // first rotation, scaled to the working format
  always_ff @(posedge clk) begin
    if (en) begin
      u_r     <= epr_pkg::u_t'(epr_pkg::rnd_sh(
                   epr_pkg::acc_t'(jsa_r) - epr_pkg::acc_t'(kca_r), epr_pkg::TO_WORK));
      v2_r    <= epr_pkg::u_t'(epr_pkg::rnd_sh(
                   epr_pkg::acc_t'(jca_r) + epr_pkg::acc_t'(ksa_r), epr_pkg::TO_WORK));
      icbw2_r <= epr_pkg::u_t'(epr_pkg::rnd_sh(epr_pkg::acc_t'(icb_r), epr_pkg::TO_WORK));
      isb2_r  <= isb_r;
      sb2_r   <= sb1_r;
      cb2_r   <= cb1_r;
      cc2_r   <= cc1_r;
      sc2_r   <= sc1_r;
    end
  end

  // second rotation products
  always_ff @(posedge clk) begin
    if (en) begin
      sbu_r   <= epr_pkg::sbu_t'(sb2_r) * epr_pkg::sbu_t'(u_r);
      cbu_r   <= epr_pkg::sbu_t'(cb2_r) * epr_pkg::sbu_t'(u_r);
      icbw3_r <= icbw2_r;
      v3_r    <= v2_r;
      isb3_r  <= isb2_r;
      cc3_r   <= cc2_r;
      sc3_r   <= sc2_r;
    end
  end

  // second rotation sums, z result is final here
  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= epr_pkg::psum_t'(epr_pkg::acc_t'(icbw3_r)
               + epr_pkg::rnd_sh(epr_pkg::acc_t'(sbu_r), epr_pkg::TRIG_FRAC_BITS));
      z4_r  <= epr_pkg::sat_out(epr_pkg::rnd_sh(
                 (epr_pkg::acc_t'(isb3_r) <<< epr_pkg::WORK_FRAC)
                 - epr_pkg::acc_t'(cbu_r), epr_pkg::TO_OUT));
      v4_r  <= v3_r;
      cc4_r <= cc3_r;
      sc4_r <= sc3_r;
    end
  end

  // third rotation products
  always_ff @(posedge clk) begin
    if (en) begin
      ccp_r <= epr_pkg::mprod_t'(cc4_r) * epr_pkg::mprod_t'(p_r);
      scv_r <= epr_pkg::mprod_t'(sc4_r) * epr_pkg::mprod_t'(v4_r);
      ccv_r <= epr_pkg::mprod_t'(cc4_r) * epr_pkg::mprod_t'(v4_r);
      scp_r <= epr_pkg::mprod_t'(sc4_r) * epr_pkg::mprod_t'(p_r);
      z5_r  <= z4_r;
    end
  end

  // third rotation sums, round to Q16.8 and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.rot_x <= epr_pkg::sat_out(epr_pkg::rnd_sh(
                       epr_pkg::acc_t'(ccp_r) + epr_pkg::acc_t'(scv_r), epr_pkg::TO_OUT));
      res_r.rot_y <= epr_pkg::sat_out(epr_pkg::rnd_sh(
                       epr_pkg::acc_t'(ccv_r) - epr_pkg::acc_t'(scp_r), epr_pkg::TO_OUT));
      res_r.rot_z <= z5_r;
    end
  end

  assign res = res_r;

endmodule

>>> sv/euler_point_rotate.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_point_rotate: 3-D point rotation by three angles
// Pipeline: 13 register stages, 7 in the sine/cosine lanes and 6 in the
//   rotate stage.
// Throughput: one word per cycle while the skid register is empty.
// An output skid register holds a stalled word while the pipeline shifts.
// Reset clears the stage valid flags and the skid flag; data is not reset.
// ---------------------------------------------------------------------------
module euler_point_rotate (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // coord_i, coord_j, coord_k, angle_a, angle_b, angle_c
  input  logic [epr_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // rot_x, rot_y, rot_z, zero pad
  output logic [epr_pkg::OUT_DATA_W-1:0]   out_tdata
);

  logic                         en;
  logic [epr_pkg::NSTAGE-1:0]   vld_r;
  logic                         skid_vld_r, skid_vld_nxt;
  epr_pkg::res_t                skid_r, tail;
  epr_pkg::res_t                out_word;
  epr_pkg::point_t              pt_in;
  epr_pkg::point_t              crd_r [epr_pkg::LANE_STAGES];
  epr_pkg::sincos_t             sc_a, sc_b, sc_c;

  // pipeline moves whenever the skid register is free
  assign en        = !skid_vld_r;
  assign in_tready = en;

  // unpack the point
  always_comb begin
    pt_in.i = epr_pkg::coord_t'(in_tdata[15:0]);
    pt_in.j = epr_pkg::coord_t'(in_tdata[31:16]);
    pt_in.k = epr_pkg::coord_t'(in_tdata[47:32]);
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[epr_pkg::NSTAGE-2:0], in_tvalid};
    end
  end

  // point delay matching the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      crd_r[0] <= pt_in;
      for (int s = 1; s < epr_pkg::LANE_STAGES; s++) begin
        crd_r[s] <= crd_r[s-1];
      end
    end
  end

  // one lane per angle
  epr_lane u_lane_a (
    .clk   (clk),
    .en    (en),
    .angle (in_tdata[63:48]),
    .sc    (sc_a)
  );

  epr_lane u_lane_b (
    .clk   (clk),
    .en    (en),
    .angle (in_tdata[79:64]),
    .sc    (sc_b)
  );

  epr_lane u_lane_c (
    .clk   (clk),
    .en    (en),
    .angle (in_tdata[95:80]),
    .sc    (sc_c)
  );

  // merge
  epr_rotate u_rotate (
    .clk   (clk),
    .en    (en),
    .pt    (crd_r[epr_pkg::LANE_STAGES-1]),
    .ang_a (sc_a),
    .ang_b (sc_b),
    .ang_c (sc_c),
    .res   (tail)
  );

  // skid flag: catch a stalled tail word before the pipeline shifts
  always_comb begin
    priority if (skid_vld_r) begin
      skid_vld_nxt = !out_tready;
    end else begin
      skid_vld_nxt = vld_r[epr_pkg::NSTAGE-1] && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      skid_r <= tail;
    end
  end

  // output word
  assign out_word   = skid_vld_r ? skid_r : tail;
  assign out_tvalid = skid_vld_r || vld_r[epr_pkg::NSTAGE-1];
  assign out_tdata  = {{(epr_pkg::OUT_DATA_W - 3 * epr_pkg::OUT_W){1'b0}}, out_word};

  // a stalled tail word moves into the skid register
  a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !skid_vld_r |=> skid_vld_r)
    else $error("stalled word not held in skid register");

  // a taken skid word frees the register
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && out_tready |=> !skid_vld_r)
    else $error("skid register not released");

  // pipeline frozen while the skid register is full
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |=> $stable(vld_r))
    else $error("pipeline moved while skid register full");

  // an accepted word enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted word lost at pipeline entry");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for euler_point_rotate
// Streams points with three rotation angles into the rotator and predicts
// each rotated point in fixed point from the quarter-wave sine scheme.
// Every output word is compared field by field against the oldest pending
// prediction. Directed corner points come first, then random points under
// several source-gap and sink-stall mixes.
// ---------------------------------------------------------------------------
module tb;

  localparam int    CLK_HALF    = 5;
  localparam int    RESET_LEN   = 5;
  localparam int    PHASE_WORDS = 350;
  localparam int    DRAIN_WAIT  = 40;
  localparam int    CYCLE_LIMIT = 400000;
  localparam int    REPORT_MAX  = 10;
  localparam longint unsigned PI32_RAD = 64'd105414357;
  localparam longint unsigned SINE_ONE = 64'd1073741824;

  // one input word: coord_i lowest, angle_c highest
  typedef struct packed {
    epr_pkg::angle_t c;
    epr_pkg::angle_t b;
    epr_pkg::angle_t a;
    epr_pkg::coord_t k;
    epr_pkg::coord_t j;
    epr_pkg::coord_t i;
  } rot_request_t;

  // scoreboard: predicts rotated points and checks the output stream
  class rotation_scoreboard;
    epr_pkg::res_t pending_rotations[$];
    int            mismatches;

    function new();
      mismatches = 0;
    endfunction

    // sin(n*pi/32) in Q1.30
    function automatic longint unsigned sine_sample(longint unsigned n);
      unique case (n)
        0:  return 64'd0;
        1:  return 64'd105245103;
        2:  return 64'd209476638;
        3:  return 64'd311690799;
        4:  return 64'd410903207;
        5:  return 64'd506158392;
        6:  return 64'd596538995;
        7:  return 64'd681174602;
        8:  return 64'd759250125;
        9:  return 64'd830013654;
        10: return 64'd892783698;
        11: return 64'd946955747;
        12: return 64'd992008094;
        13: return 64'd1027506862;
        14: return 64'd1053110176;
        15: return 64'd1068571464;
        default: return SINE_ONE;
      endcase
    endfunction

    // sine over a quarter turn, g is a 24-bit fraction of the quarter
    function automatic longint unsigned quarter_wave_sine(longint unsigned g);
      longint unsigned idx, r, s0, c0, d, d2, d3, pos, neg;
      idx = g >> 20;
      r   = g & 64'hFFFFF;
      if (idx >= 16) begin
        return SINE_ONE;
      end
      s0  = sine_sample(idx);
      c0  = sine_sample(16 - idx);
      d   = (r * PI32_RAD) >> 20;
      d2  = (d * d) >> 30;
      d3  = (d2 * d) >> 30;
      pos = s0 + ((c0 * d) >> 30);
      neg = ((s0 * d2) >> 31) + (((c0 * d3) >> 30) / 6);
      if (neg >= pos) begin
        return 64'd0;
      end
      pos = pos - neg;
      if (pos > SINE_ONE) begin
        pos = SINE_ONE;
      end
      return pos;
    endfunction

    // signed sine or cosine of a phase, TRIG_FRAC_BITS fraction bits
    function automatic longint phase_trig(epr_pkg::angle_t ph, bit want_cos);
      logic [epr_pkg::ANGLE_BITS-1:0] p;
      logic [1:0]                     quad;
      longint unsigned                f, g, mag;
      p = ph;
      if (want_cos) begin
        p = p + (epr_pkg::angle_t'(1) << (epr_pkg::ANGLE_BITS - 2));
      end
      quad = p[epr_pkg::ANGLE_BITS-1 -: 2];
      f    = longint'(p[epr_pkg::ANGLE_BITS-3:0]) << (26 - epr_pkg::ANGLE_BITS);
      g    = quad[0] ? ((64'd1 << 24) - f) : f;
      mag  = (quarter_wave_sine(g) + (64'd1 << (29 - epr_pkg::TRIG_FRAC_BITS)))
             >> (30 - epr_pkg::TRIG_FRAC_BITS);
      return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    // shift right with round half up, shift left when s is not positive
    function automatic longint round_half_up(longint x, int s);
      if (s <= 0) begin
        return x <<< (-s);
      end
      return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic epr_pkg::out_t clamp_q8(longint x);
      if (x > 64'sd16777215) begin
        x = 64'sd16777215;
      end
      if (x < -64'sd16777216) begin
        x = -64'sd16777216;
      end
      return epr_pkg::out_t'(x);
    endfunction

    function automatic epr_pkg::res_t predict_rotation(rot_request_t req);
      longint        ci, cj, ck, sa, ca, sb, cb, sc, cc;
      longint        u, v, p, x, y, z;
      int            to_work, to_out;
      epr_pkg::res_t res;
      ci = longint'(req.i);
      cj = longint'(req.j);
      ck = longint'(req.k);
      sa = phase_trig(req.a, 1'b0);
      ca = phase_trig(req.a, 1'b1);
      sb = phase_trig(req.b, 1'b0);
      cb = phase_trig(req.b, 1'b1);
      sc = phase_trig(req.c, 1'b0);
      cc = phase_trig(req.c, 1'b1);
      to_work = epr_pkg::TRIG_FRAC_BITS - epr_pkg::WORK_FRAC;
      to_out  = epr_pkg::TRIG_FRAC_BITS + epr_pkg::WORK_FRAC - epr_pkg::OUT_FRAC;
      // intermediate terms in Q16
      u = round_half_up(cj * sa - ck * ca, to_work);
      v = round_half_up(cj * ca + ck * sa, to_work);
      p = round_half_up(ci * cb, to_work)
          + round_half_up(sb * u, epr_pkg::TRIG_FRAC_BITS);
      // final sums in Q8
      x = round_half_up(cc * p + sc * v, to_out);
      y = round_half_up(cc * v - sc * p, to_out);
      z = round_half_up(ci * sb * (64'sd1 <<< epr_pkg::WORK_FRAC) - cb * u, to_out);
      res.rot_x = clamp_q8(x);
      res.rot_y = clamp_q8(y);
      res.rot_z = clamp_q8(z);
      return res;
    endfunction

    function void note_point(rot_request_t req);
      pending_rotations.push_back(predict_rotation(req));
    endfunction

    function void check_rotated(epr_pkg::res_t got);
      epr_pkg::res_t exp_res;
      if (pending_rotations.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected word: x=%0d y=%0d z=%0d",
                   got.rot_x, got.rot_y, got.rot_z);
        end
        return;
      end
      exp_res = pending_rotations.pop_front();
      if (got.rot_x !== exp_res.rot_x || got.rot_y !== exp_res.rot_y ||
          got.rot_z !== exp_res.rot_z) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("rotation mismatch: exp x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                   exp_res.rot_x, exp_res.rot_y, exp_res.rot_z,
                   got.rot_x, got.rot_y, got.rot_z);
        end
      end
    endfunction

    function int outstanding();
      return pending_rotations.size();
    endfunction
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [epr_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [epr_pkg::OUT_DATA_W-1:0] out_tdata;

  int                 gap_pct   = 0;
  int                 stall_pct = 0;
  int                 cycles    = 0;
  rotation_scoreboard sb;

  euler_point_rotate u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // sink: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_rotated(epr_pkg::res_t'(out_tdata[3*epr_pkg::OUT_W-1:0]));
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // send one word, idling at random before it
  task automatic send_point(rot_request_t req);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    sb.note_point(req);
  endtask

  task automatic send_fields(int i, int j, int k, int a, int b, int c);
    rot_request_t req;
    req.i = epr_pkg::coord_t'(i);
    req.j = epr_pkg::coord_t'(j);
    req.k = epr_pkg::coord_t'(k);
    req.a = epr_pkg::angle_t'(a);
    req.b = epr_pkg::angle_t'(b);
    req.c = epr_pkg::angle_t'(c);
    send_point(req);
  endtask

  // coordinates mostly uniform, some at the extremes or near zero
  function automatic epr_pkg::coord_t random_coord();
    unique case ($urandom_range(9))
      0:       return epr_pkg::coord_t'(-32768);
      1:       return epr_pkg::coord_t'(32767);
      2:       return epr_pkg::coord_t'($urandom_range(2) - 1);
      default: return epr_pkg::coord_t'($urandom);
    endcase
  endfunction

  // angles mostly uniform, some near quarter-turn and table boundaries
  function automatic epr_pkg::angle_t random_angle();
    unique case ($urandom_range(7))
      0:       return epr_pkg::angle_t'(($urandom_range(3) << 14) + $urandom_range(16) - 8);
      1:       return epr_pkg::angle_t'(($urandom_range(63) << 10) + $urandom_range(2) - 1);
      default: return epr_pkg::angle_t'($urandom);
    endcase
  endfunction

  initial begin
    rot_request_t req;
    sb = new();
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: zero, extremes, quadrants, table steps, large norms
    send_fields(0, 0, 0, 0, 0, 0);
    send_fields(32767, 32767, 32767, 0, 0, 0);
    send_fields(-32768, -32768, -32768, 0, 0, 0);
    send_fields(1000, -2000, 3000, 16384, 0, 0);
    send_fields(1000, -2000, 3000, 0, 32768, 0);
    send_fields(1000, -2000, 3000, 0, 0, 49152);
    send_fields(1000, -2000, 3000, 49152, 16384, 32768);
    send_fields(-1, 1, -1, 65535, 65535, 65535);
    send_fields(12345, -54, 777, 1, 1, 1);
    send_fields(500, 600, -700, 1024, 1023, 1025);
    send_fields(500, 600, -700, 15360, 16383, 16385);
    send_fields(-32768, -32768, -32768, 57344, 9000, 8192);
    send_fields(32767, 32767, 32767, 8192, 55000, 24576);
    send_fields(-32768, 32767, -32768, 40960, 6000, 60000);
    send_fields(32767, -32768, 32767, 24576, 43000, 5461);
    send_fields(-32768, 0, 0, 0, 16384, 16384);
    send_fields(0, -32768, 0, 32768, 32768, 32768);
    send_fields(0, 0, 32767, 8192, 8192, 8192);
    send_fields(21845, -10923, 4369, 43690, 21845, 65280);
    send_fields(-100, 200, -300, 255, 4096, 61440);

    // random points under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 66; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 66; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      repeat (PHASE_WORDS) begin
        req.i = random_coord();
        req.j = random_coord();
        req.k = random_coord();
        req.a = random_angle();
        req.b = random_angle();
        req.c = random_angle();
        send_point(req);
      end
    end
    in_tvalid <= 1'b0;

    // drain and watch for stray words
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
